// ===== hw/rtl/fmpt_pkg.sv =====
// Shared types and constants of the flow meter period totalizer.
`timescale 1ns / 1ps

package fmpt_pkg;

	// Fixed field widths.
	localparam int KIND_W    = 2;
	localparam int TIME_W    = 32;
	localparam int FPC_W     = 32;
	localparam int THR_W     = 12;
	localparam int TOT_W     = 64;
	localparam int AVG_W     = 44;
	localparam int ERR_W     = 2;
	localparam int CNT_OUT_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	// Shared adder width: holds the full 44 x 32 bit product.
	localparam int ACC_W = AVG_W + TIME_W;

	// Step counter and step counts of the sequencer.
	localparam int STEP_W   = 7;
	localparam int DIV_STEPS = TOT_W;
	localparam int MUL_STEPS = TIME_W;

	// Item kinds.
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_SAMPLE = 2'd0;
	localparam kind_t KIND_CLOSE  = 2'd1;
	localparam kind_t KIND_BEGIN  = 2'd2;

	// Error codes.
	typedef logic [ERR_W-1:0] err_t;
	localparam err_t ERR_NONE     = 2'd0;
	localparam err_t ERR_VOLTAGE  = 2'd1;
	localparam err_t ERR_NO_VALID = 2'd2;

	// Configuration register indexes.
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_FLOW_PER_COUNT  = 2'd0;
	localparam cfg_idx_t REG_VALID_THRESHOLD = 2'd1;
	localparam cfg_idx_t REG_RESTORED_TOTAL  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [FPC_W-1:0] FPC_RESET = 32'd65536;
	localparam logic [THR_W-1:0] THR_RESET = 12'd737;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_MSET,
		ST_TOT
	} state_t;

endpackage

// ===== hw/rtl/fmpt_if.sv =====
// Channel interfaces of the flow meter period totalizer.
`timescale 1ns / 1ps

// Input word channel.
interface fmpt_in_if import fmpt_pkg::*; #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      kind;
	logic [SAMPLE_BITS-1:0] adc_sample;
	logic [TIME_W-1:0]      epoch_time;

	modport source (output valid, kind, adc_sample, epoch_time, input ready);
	modport sink   (input valid, kind, adc_sample, epoch_time, output ready);
endinterface

// Result word channel.
interface fmpt_out_if import fmpt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [AVG_W-1:0]     average_flow;
	logic [TOT_W-1:0]     period_consumption;
	logic [TOT_W-1:0]     total_consumption;
	logic [TIME_W-1:0]    period_start;
	logic [TIME_W-1:0]    period_end;
	logic [ERR_W-1:0]     error_code;
	logic [CNT_OUT_W-1:0] invalid_samples;
	logic [CNT_OUT_W-1:0] valid_samples;

	modport source (output valid, average_flow, period_consumption, total_consumption,
		period_start, period_end, error_code, invalid_samples, valid_samples,
		input ready);
	modport sink   (input valid, average_flow, period_consumption, total_consumption,
		period_start, period_end, error_code, invalid_samples, valid_samples,
		output ready);
endinterface

// Configuration write channel.
interface fmpt_cfg_if import fmpt_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/flow_meter_period_totalizer.sv =====
// Flow meter period totalizer: sample accumulation, period average and running total.
//
//  channel | modport | handshake     | word
//  --------+---------+---------------+-----------------------------------------------
//  item    | sink    | valid / ready | kind, adc_sample, epoch_time
//  result  | source  | valid / ready | average, consumptions, times, error, counts
//  cfg     | sink    | valid / ready | register index, write data (always ready)
//
// One shared 76-bit add/subtract unit does all arithmetic, one step per cycle.
// A valid sample runs a shift-add multiply, then the sum add;
// invalid samples, begin and ignored words are done in the accept step alone.
// A period close runs an accept step, 64 divide steps, a setup step, 32 multiply steps
// and the total add (with no valid samples the divide is skipped);
// the 64-bit restoring division is the longest part of it.
// item.ready is high only while the sequencer is idle. A finished result waits in the
// result register without blocking new words; only the next close waits for it to drain.
// arst_n clears the sequencer and accumulators and resets the configuration registers.
`timescale 1ns / 1ps

module flow_meter_period_totalizer import fmpt_pkg::*; #(
	parameter int COUNT_BITS  = 20,
	parameter int SAMPLE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	fmpt_in_if.sink     item,
	fmpt_out_if.source  result,
	fmpt_cfg_if.sink    cfg
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	// Configuration registers.
	logic [FPC_W-1:0] flow_per_count_q;
	logic [THR_W-1:0] valid_threshold_q;
	logic [TOT_W-1:0] restored_total_q;

	// Architectural state.
	logic [TIME_W-1:0]     start_time_q;
	logic [TOT_W-1:0]      flow_sum_q;
	logic [COUNT_BITS-1:0] valid_count_q;
	logic [COUNT_BITS-1:0] invalid_count_q;
	err_t                  pending_error_q;
	logic [TOT_W-1:0]      running_total_q;

	// Sequencer and working registers.
	state_t                state_q, state_d;
	kind_t                 kind_q;
	logic [TIME_W-1:0]     end_q;
	err_t                  err_q;
	logic [STEP_W-1:0]     step_q;
	logic [ACC_W-1:0]      acc_q;
	logic [AVG_W-1:0]      mcand_q;
	logic [TIME_W-1:0]     mplier_q;
	logic [TOT_W-1:0]      dq_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [AVG_W-1:0]      avg_q;

	// Result register.
	logic                  out_valid_q;
	logic [AVG_W-1:0]      out_avg_q;
	logic [TOT_W-1:0]      out_period_q;
	logic [TOT_W-1:0]      out_total_q;
	logic [TIME_W-1:0]     out_start_q;
	logic [TIME_W-1:0]     out_end_q;
	err_t                  out_err_q;
	logic [CNT_OUT_W-1:0]  out_invalid_q;
	logic [CNT_OUT_W-1:0]  out_valid_cnt_q;

	// Shared adder.
	logic [ACC_W-1:0] add_a;
	logic [ACC_W-1:0] add_b;
	logic             add_sub;
	logic [ACC_W:0]   add_res;

	logic             in_fire;
	logic             sample_gt;
	logic             slot_free;
	logic             div_ge;
	logic [AVG_W-1:0] avg_sat;
	logic [TOT_W-1:0] period_sat;
	logic [TOT_W-1:0] total_sat;
	logic [TOT_W-1:0] sum_sat;

	// The one add/subtract unit; the top bit is carry out, or "no borrow" on subtract.
	assign add_res = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (ACC_W + 1)'(add_sub);

	assign in_fire   = item.valid && item.ready;
	assign sample_gt = CMP_W'(item.adc_sample) > CMP_W'(valid_threshold_q);
	assign slot_free = !out_valid_q || result.ready;
	assign div_ge    = add_res[ACC_W];

	// Saturation of the quotient, the product, the running total and the flow sum.
	assign avg_sat    = (|dq_q[TOT_W-1:AVG_W]) ? '1 : dq_q[AVG_W-1:0];
	assign period_sat = (|acc_q[ACC_W-1:TOT_W]) ? '1 : acc_q[TOT_W-1:0];
	assign total_sat  = (|add_res[ACC_W:TOT_W]) ? '1 : add_res[TOT_W-1:0];
	assign sum_sat    = total_sat;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (item.kind == KIND_SAMPLE && sample_gt) begin
						state_d = ST_MUL;
					end else if (item.kind == KIND_CLOSE) begin
						state_d = (valid_count_q != '0) ? ST_DIV : ST_MSET;
					end
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(1)) begin
					state_d = (kind_q == KIND_CLOSE) ? ST_TOT : ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(1)) begin
					state_d = ST_MSET;
				end
			end
			ST_MSET: begin
				state_d = ST_MUL;
			end
			ST_TOT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake and adder operand selection per state.
	always_comb begin
		item.ready = 1'b0;
		add_a      = '0;
		add_b      = '0;
		add_sub    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
			end
			ST_MUL: begin
				add_a = {acc_q[ACC_W-2:0], 1'b0};
				add_b = mplier_q[TIME_W-1] ? ACC_W'(mcand_q) : '0;
			end
			ST_SUM: begin
				add_a = ACC_W'(flow_sum_q);
				add_b = acc_q;
			end
			ST_DIV: begin
				add_a   = ACC_W'({rem_q, dq_q[TOT_W-1]});
				add_b   = ACC_W'(valid_count_q);
				add_sub = 1'b1;
			end
			ST_MSET: begin
				add_a   = ACC_W'(end_q);
				add_b   = ACC_W'(start_time_q);
				add_sub = 1'b1;
			end
			ST_TOT: begin
				add_a = ACC_W'(running_total_q);
				add_b = ACC_W'(period_sat);
			end
			default: begin
				item.ready = 1'b0;
			end
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_per_count_q  <= FPC_RESET;
			valid_threshold_q <= THR_RESET;
			restored_total_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FLOW_PER_COUNT:  flow_per_count_q  <= cfg.data[FPC_W-1:0];
				REG_VALID_THRESHOLD: valid_threshold_q <= cfg.data[THR_W-1:0];
				REG_RESTORED_TOTAL:  restored_total_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Period accumulators, start time and running total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			flow_sum_q      <= '0;
			valid_count_q   <= '0;
			invalid_count_q <= '0;
			pending_error_q <= ERR_NONE;
			running_total_q <= '0;
		end else begin
			if (state_q == ST_IDLE && in_fire) begin
				if (item.kind == KIND_SAMPLE && !sample_gt) begin
					if (invalid_count_q != '1) begin
						invalid_count_q <= invalid_count_q + COUNT_BITS'(1);
					end
					pending_error_q <= ERR_VOLTAGE;
				end else if (item.kind == KIND_BEGIN) begin
					start_time_q    <= item.epoch_time;
					running_total_q <= restored_total_q;
				end
			end
			if (state_q == ST_SUM) begin
				flow_sum_q <= sum_sat;
				if (valid_count_q != '1) begin
					valid_count_q <= valid_count_q + COUNT_BITS'(1);
				end
				pending_error_q <= ERR_NONE;
			end
			if (state_q == ST_TOT && slot_free) begin
				running_total_q <= total_sat;
				start_time_q    <= end_q;
				flow_sum_q      <= '0;
				valid_count_q   <= '0;
				invalid_count_q <= '0;
				pending_error_q <= ERR_NONE;
			end
		end
	end

	// Working registers of the shift-add multiplier and the restoring divider.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					kind_q <= item.kind;
					end_q  <= item.epoch_time;
					if (item.kind == KIND_SAMPLE) begin
						acc_q    <= '0;
						mcand_q  <= AVG_W'(flow_per_count_q);
						mplier_q <= TIME_W'(item.adc_sample) << (TIME_W - SAMPLE_BITS);
						step_q   <= STEP_W'(SAMPLE_BITS);
					end else if (item.kind == KIND_CLOSE) begin
						err_q  <= (valid_count_q != '0) ? pending_error_q : ERR_NO_VALID;
						dq_q   <= (valid_count_q != '0) ? flow_sum_q : '0;
						rem_q  <= '0;
						step_q <= STEP_W'(DIV_STEPS);
					end
				end
			end
			ST_MUL: begin
				acc_q    <= add_res[ACC_W-1:0];
				mplier_q <= {mplier_q[TIME_W-2:0], 1'b0};
				step_q   <= step_q - STEP_W'(1);
			end
			ST_DIV: begin
				rem_q  <= div_ge ? add_res[COUNT_BITS-1:0]
					: {rem_q[COUNT_BITS-2:0], dq_q[TOT_W-1]};
				dq_q   <= {dq_q[TOT_W-2:0], div_ge};
				step_q <= step_q - STEP_W'(1);
			end
			ST_MSET: begin
				// Elapsed seconds wrap modulo 2^32.
				mplier_q <= add_res[TIME_W-1:0];
				mcand_q  <= avg_sat;
				avg_q    <= avg_sat;
				acc_q    <= '0;
				step_q   <= STEP_W'(MUL_STEPS);
			end
			default: begin
			end
		endcase
	end

	// Result register: loaded at the end of a close, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_TOT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TOT && slot_free) begin
			out_avg_q       <= avg_q;
			out_period_q    <= period_sat;
			out_total_q     <= total_sat;
			out_start_q     <= start_time_q;
			out_end_q       <= end_q;
			out_err_q       <= err_q;
			out_invalid_q   <= CNT_OUT_W'(invalid_count_q);
			out_valid_cnt_q <= CNT_OUT_W'(valid_count_q);
		end
	end

	assign result.valid              = out_valid_q;
	assign result.average_flow       = out_avg_q;
	assign result.period_consumption = out_period_q;
	assign result.total_consumption  = out_total_q;
	assign result.period_start       = out_start_q;
	assign result.period_end         = out_end_q;
	assign result.error_code         = out_err_q;
	assign result.invalid_samples    = out_invalid_q;
	assign result.valid_samples      = out_valid_cnt_q;

	// A new result only ever comes out of the total add.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_TOT)
		else $error("result raised outside the total add");

	// The divider only runs with a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> valid_count_q != '0)
		else $error("division started with zero valid samples");

	// The partial remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < valid_count_q)
		else $error("divider remainder out of range");

	// Iterating states never run with an exhausted step count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_DIV) |-> step_q != '0)
		else $error("step counter ran out");

	// The flow sum holds through the divide and setup steps of a close.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_MSET) |=> $stable(flow_sum_q))
		else $error("flow sum changed during a close");

endmodule
